FILE: design/debug_packet_receiver_unit_defines.svh
// Assertion macros used by the receiver datapath
`ifndef DEBUG_PACKET_RECEIVER_UNIT_DEFINES_SVH
`define DEBUG_PACKET_RECEIVER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define DPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle
`define DPR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle
`define DPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dpr_pkg.sv
package dpr_pkg;

    // Framing characters
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ACK   = 8'h2B;
    localparam logic [7:0] CH_NAK   = 8'h2D;

    // Result word kinds
    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2
    } dpr_kind_t;

    // Source of a result word
    typedef enum logic [1:0] {
        PS_NAK  = 2'd0,
        PS_ACK  = 2'd1,
        PS_DATA = 2'd2,
        PS_END  = 2'd3
    } dpr_push_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_HUNT    = 4'd0,
        ST_PAYLOAD = 4'd1,
        ST_HI      = 4'd2,
        ST_LO      = 4'd3,
        ST_NAK     = 4'd4,
        ST_ACK     = 4'd5,
        ST_COLON   = 4'd6,
        ST_RD      = 4'd7,
        ST_PUT     = 4'd8,
        ST_END     = 4'd9
    } dpr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic      pkt_clear;
        logic      store;
        logic      hi_load;
        logic      rd_en;
        logic      rd_at_two;
        logic      idx_clear;
        logic      idx_step;
        logic      push;
        dpr_push_t push_sel;
    } dpr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_end;
        logic full;
        logic ck_ok;
        logic colon_ok;
        logic empty;
        logic more;
        logic slot_free;
    } dpr_stat_t;

    // Hex digit value; bit 4 set marks a bad digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
            v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            v = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            v = {1'b0, 4'(c - 8'h37)};
        return v;
    endfunction

endpackage

FILE: design/dpr_rx_if.sv
// Received byte channel
interface dpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: design/dpr_res_if.sv
// Result word channel
interface dpr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_kind, output out_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_last,
                    output ready);
endinterface

FILE: design/dpr_datapath.sv
// Packet store, checksum, read pointer and result register
module dpr_datapath #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  dpr_pkg::dpr_cmd_t  cmd,
    output dpr_pkg::dpr_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_kind,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    `include "debug_packet_receiver_unit_defines.svh"

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]    mem [BUFFER_BYTES];
    logic [CW-1:0] count_reg;
    logic [7:0]    sum_reg;
    logic [4:0]    hi_reg;
    logic [7:0]    rd_data_reg;
    logic [CW-1:0] idx_reg;
    logic          echo_reg;
    logic          out_valid_reg;
    logic [1:0]    kind_reg;
    logic [7:0]    byte_reg;
    logic          last_reg;

    logic [4:0]    lo_val;
    logic [CW-1:0] idx_next;
    logic [AW-1:0] rd_addr;
    logic          colon_ok;
    logic          slot_free;
    logic [1:0]    push_kind;
    logic [7:0]    push_byte;
    logic          push_last;

    // Status decode
    assign lo_val    = dpr_pkg::hex_value(rx_byte);
    assign colon_ok  = (count_reg >= CW'(3)) && (rd_data_reg == dpr_pkg::CH_COLON);
    assign slot_free = !out_valid_reg || out_ready;
    assign idx_next  = (echo_reg && idx_reg == CW'(1)) ? CW'(3) : idx_reg + CW'(1);
    assign rd_addr   = cmd.rd_at_two ? AW'(2) : idx_reg[AW-1:0];

    always_comb
    begin
        stat.is_start  = (rx_byte == dpr_pkg::CH_START);
        stat.is_end    = (rx_byte == dpr_pkg::CH_END);
        stat.full      = (count_reg == CW'(BUFFER_BYTES));
        stat.ck_ok     = !hi_reg[4] && !lo_val[4] && ({hi_reg[3:0], lo_val[3:0]} == sum_reg);
        stat.colon_ok  = colon_ok;
        stat.empty     = (count_reg == '0);
        stat.more      = (idx_next < count_reg);
        stat.slot_free = slot_free;
    end

    // Packet count and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            if (cmd.pkt_clear)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            else if (cmd.store)
            begin
                count_reg <= count_reg + CW'(1);
                sum_reg   <= sum_reg + rx_byte;
            end
            if (cmd.hi_load)
                hi_reg <= dpr_pkg::hex_value(rx_byte);
        end
    end

    // Payload store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[count_reg[AW-1:0]] <= rx_byte;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Delivery pointer and sequence id flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            echo_reg <= 1'b0;
        end
        else if (cmd.idx_clear)
        begin
            idx_reg  <= '0;
            echo_reg <= colon_ok;
        end
        else if (cmd.idx_step)
            idx_reg <= idx_next;
    end

    // Result word select
    always_comb
    begin
        push_kind = dpr_pkg::KIND_TX;
        push_byte = '0;
        push_last = 1'b0;
        case (cmd.push_sel)
            dpr_pkg::PS_NAK:
            begin
                push_byte = dpr_pkg::CH_NAK;
                push_last = 1'b1;
            end
            dpr_pkg::PS_ACK:
                push_byte = dpr_pkg::CH_ACK;
            dpr_pkg::PS_DATA:
            begin
                push_byte = rd_data_reg;
                push_kind = (echo_reg && idx_reg < CW'(2)) ? dpr_pkg::KIND_TX
                                                          : dpr_pkg::KIND_PAYLOAD;
            end
            default:
            begin
                push_kind = dpr_pkg::KIND_END;
                push_last = 1'b1;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.push)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            kind_reg <= push_kind;
            byte_reg <= push_byte;
            last_reg <= push_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    // Checks
    `DPR_ASSERT_ALWAYS(a_count_range, count_reg <= CW'(BUFFER_BYTES), "count beyond buffer")
    `DPR_ASSERT_IMPL(a_store_room, cmd.store, count_reg < CW'(BUFFER_BYTES), "store when full")
    `DPR_ASSERT_IMPL(a_push_free, cmd.push, slot_free, "result word overwritten")
    `DPR_ASSERT_IMPL(a_read_written, cmd.rd_en && !cmd.rd_at_two, idx_reg < count_reg,
        "read of unwritten entry")
    `DPR_ASSERT_NEXT(a_push_shows, cmd.push, out_valid_reg, "pushed word not shown")

endmodule

FILE: design/dpr_ctrl.sv
// Framing and delivery sequencer
module dpr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dpr_pkg::dpr_stat_t stat,
    output dpr_pkg::dpr_cmd_t  cmd
);

    dpr_pkg::dpr_state_t state_reg;
    dpr_pkg::dpr_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dpr_pkg::ST_HUNT;
        else
            state_reg <= state_next;
    end

    // Next state and commands; ready is high in every framing state,
    // so a valid word there is a taken word
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            dpr_pkg::ST_HUNT:
            begin
                in_ready = 1'b1;
                if (in_valid && stat.is_start)
                begin
                    cmd.pkt_clear = 1'b1;
                    state_next    = dpr_pkg::ST_PAYLOAD;
                end
            end
            dpr_pkg::ST_PAYLOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.is_end)
                        state_next = dpr_pkg::ST_HI;
                    else if (stat.is_start)
                        cmd.pkt_clear = 1'b1;
                    else if (stat.full)
                    begin
                        cmd.pkt_clear = 1'b1;
                        state_next    = dpr_pkg::ST_HUNT;
                    end
                    else
                        cmd.store = 1'b1;
                end
            end
            dpr_pkg::ST_HI:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.hi_load = 1'b1;
                    state_next  = dpr_pkg::ST_LO;
                end
            end
            dpr_pkg::ST_LO:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = stat.ck_ok ? dpr_pkg::ST_ACK : dpr_pkg::ST_NAK;
            end
            dpr_pkg::ST_NAK:
            begin
                cmd.push_sel = dpr_pkg::PS_NAK;
                if (stat.slot_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = dpr_pkg::ST_HUNT;
                end
            end
            dpr_pkg::ST_ACK:
            begin
                // fetch byte 2 for the sequence id check
                cmd.rd_en     = 1'b1;
                cmd.rd_at_two = 1'b1;
                cmd.push_sel  = dpr_pkg::PS_ACK;
                if (stat.slot_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = dpr_pkg::ST_COLON;
                end
            end
            dpr_pkg::ST_COLON:
            begin
                cmd.idx_clear = 1'b1;
                state_next    = (stat.colon_ok || !stat.empty) ? dpr_pkg::ST_RD
                                                               : dpr_pkg::ST_END;
            end
            dpr_pkg::ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = dpr_pkg::ST_PUT;
            end
            dpr_pkg::ST_PUT:
            begin
                cmd.push_sel = dpr_pkg::PS_DATA;
                if (stat.slot_free)
                begin
                    cmd.push     = 1'b1;
                    cmd.idx_step = 1'b1;
                    state_next   = stat.more ? dpr_pkg::ST_RD : dpr_pkg::ST_END;
                end
            end
            dpr_pkg::ST_END:
            begin
                cmd.push_sel = dpr_pkg::PS_END;
                if (stat.slot_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = dpr_pkg::ST_HUNT;
                end
            end
            default:
                state_next = dpr_pkg::ST_HUNT;
        endcase
    end

endmodule

FILE: design/debug_packet_receiver_unit.sv
// Debug packet receiver. Takes serial bytes one word at a time, finds '$'-framed packets,
// checks the two hex checksum digits after '#' and answers with '-' or '+'; on '+' it
// echoes a two-byte sequence id when byte 2 is ':', delivers the payload and closes with
// an end marker. While framing, one received word is taken every cycle. After the second
// checksum digit no input is taken until the reply is out: NAK pushes '-'; ACK pushes '+'
// and fetches byte 2 for the sequence id check in COLON; each echoed or delivered byte
// takes a registered read of the payload memory (RD), then a load of the result register
// (PUT); END pushes the end marker. Every push waits while the result sink stalls.
// A packet longer than BUFFER_BYTES is dropped without reply.
module debug_packet_receiver_unit #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    dpr_rx_if.sink       byte_ch,
    dpr_res_if.source    result_ch
);

    dpr_pkg::dpr_cmd_t  cmd;
    dpr_pkg::dpr_stat_t stat;

    dpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_ch.valid),
        .in_ready (byte_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpr_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (byte_ch.rx_byte),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .out_kind  (result_ch.out_kind),
        .out_byte  (result_ch.out_byte),
        .out_last  (result_ch.out_last)
    );

endmodule

FILE: tb/sv/dpr_reply_checker.sv
// Watches both channels of the packet receiver, predicts the reply words from the
// received bytes and compares every result word against the oldest prediction.
module dpr_reply_checker #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic clk,
    input  logic rst_n,
    dpr_rx_if    byte_ch,
    dpr_res_if   result_ch,
    output int   fail_count,
    output int   words_pending
);

    // Framing phase of the predictor
    typedef enum logic [1:0] {
        FR_HUNT   = 2'd0,
        FR_BODY   = 2'd1,
        FR_SUM_HI = 2'd2,
        FR_SUM_LO = 2'd3
    } frame_phase_t;

    typedef struct packed {
        dpr_pkg::dpr_kind_t kind;
        logic [7:0]         data;
        logic               last;
    } reply_word_t;

    reply_word_t  reply_q[$];
    frame_phase_t frame_phase;
    logic [5:0]   stored;
    logic [7:0]   sum;
    logic [4:0]   hi_digit;
    logic [7:0]   payload_mem [BUFFER_BYTES];
    int           mismatches;

    // Value of a hex digit; bit 4 flags anything that is not one
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, c[3:0]};
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    // Advance the framing state by one received byte and queue its reply words
    task automatic take_byte(input logic [7:0] c);
        logic [4:0] lo;
        int         first;
        case (frame_phase)
            FR_HUNT:
            begin
                if (c == dpr_pkg::CH_START)
                begin
                    stored = '0;
                    sum = '0;
                    frame_phase = FR_BODY;
                end
            end
            FR_BODY:
            begin
                if (c == dpr_pkg::CH_END)
                    frame_phase = FR_SUM_HI;
                else if (c == dpr_pkg::CH_START)
                begin
                    stored = '0;
                    sum = '0;
                end
                else if (stored >= BUFFER_BYTES)
                begin
                    // overflow: packet dropped without reply
                    stored = '0;
                    sum = '0;
                    frame_phase = FR_HUNT;
                end
                else
                begin
                    payload_mem[stored] = c;
                    stored = stored + 6'd1;
                    sum = sum + c;
                end
            end
            FR_SUM_HI:
            begin
                hi_digit = digit_value(c);
                frame_phase = FR_SUM_LO;
            end
            default:
            begin
                lo = digit_value(c);
                frame_phase = FR_HUNT;
                if (hi_digit[4] || lo[4] || {hi_digit[3:0], lo[3:0]} != sum)
                    reply_q.push_back(reply_word_t'{dpr_pkg::KIND_TX, dpr_pkg::CH_NAK, 1'b1});
                else
                begin
                    reply_q.push_back(reply_word_t'{dpr_pkg::KIND_TX, dpr_pkg::CH_ACK, 1'b0});
                    first = 0;
                    // sequence id echoed when byte 2 is the colon
                    if (stored >= 3 && payload_mem[2] == dpr_pkg::CH_COLON)
                    begin
                        reply_q.push_back(reply_word_t'{dpr_pkg::KIND_TX, payload_mem[0],
                                                        1'b0});
                        reply_q.push_back(reply_word_t'{dpr_pkg::KIND_TX, payload_mem[1],
                                                        1'b0});
                        first = 3;
                    end
                    for (int i = first; i < int'(stored); i++)
                        reply_q.push_back(reply_word_t'{dpr_pkg::KIND_PAYLOAD, payload_mem[i],
                                                        1'b0});
                    reply_q.push_back(reply_word_t'{dpr_pkg::KIND_END, 8'h00, 1'b1});
                end
            end
        endcase
    endtask

    // Predict on accepted bytes, compare on accepted result words
    always @(posedge clk or negedge rst_n)
    begin
        reply_word_t want;
        if (!rst_n)
        begin
            reply_q.delete();
            frame_phase = FR_HUNT;
            stored = '0;
            sum = '0;
            hi_digit = '0;
            mismatches = 0;
            fail_count <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                take_byte(byte_ch.rx_byte);
            if (result_ch.valid && result_ch.ready)
            begin
                if (reply_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected word kind=%0d byte=%02h last=%b", $realtime,
                                 result_ch.out_kind, result_ch.out_byte, result_ch.out_last);
                    mismatches++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (result_ch.out_kind !== want.kind || result_ch.out_byte !== want.data
                        || result_ch.out_last !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: word mismatch: expected kind=%0d byte=%02h ",
                                      "last=%b, got kind=%0d byte=%02h last=%b"}, $realtime,
                                     want.kind, want.data, want.last, result_ch.out_kind,
                                     result_ch.out_byte, result_ch.out_last);
                        mismatches++;
                    end
                end
            end
            fail_count <= mismatches;
            words_pending <= reply_q.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// Top: serial byte stimulus, result sink with random stalls, watchdog and verdict.
module testbench;

    localparam int BUFFER_BYTES = 32;
    localparam int STALL_LIMIT  = 1000;
    localparam int IDLE_PCT     = 36;

    // Ways a generated packet can be spoilt
    typedef enum logic [1:0] {
        FLAW_NONE   = 2'd0,
        FLAW_SUM    = 2'd1,
        FLAW_HI_BAD = 2'd2,
        FLAW_LO_BAD = 2'd3
    } flaw_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic [7:0] stim_q[$];
    int         sent = 0;
    int         cycle = 0;
    int         stall = 0;
    int         fail_count;
    int         words_pending;
    logic       calm;

    dpr_rx_if  byte_ch ();
    dpr_res_if result_ch ();

    debug_packet_receiver_unit #(.BUFFER_BYTES(BUFFER_BYTES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    dpr_reply_checker #(.BUFFER_BYTES(BUFFER_BYTES)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_ch       (byte_ch),
        .result_ch     (result_ch),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // no idling on either side inside this window
    assign calm = (cycle >= 600 && cycle < 1100);

    // Hex digit character, random case for letters
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    // Something that is not a hex digit, framing characters included
    function automatic logic [7:0] non_hex();
        case ($urandom_range(0, 7))
            0: return dpr_pkg::CH_START;
            1: return dpr_pkg::CH_END;
            2: return 8'h67;
            3: return 8'h47;
            4: return dpr_pkg::CH_COLON;
            5: return 8'h00;
            6: return 8'hFF;
            default: return 8'h80 | 8'($urandom_range(0, 127));
        endcase
    endfunction

    // Payload byte that neither ends nor restarts the packet
    function automatic logic [7:0] body_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == dpr_pkg::CH_START || v == dpr_pkg::CH_END);
        return v;
    endfunction

    // Frame a body with '$', '#' and its checksum digits
    task automatic add_packet(input logic [7:0] body[$], input flaw_t flaw);
        logic [7:0] ck;
        logic [7:0] hi_c;
        logic [7:0] lo_c;
        ck = '0;
        stim_q.push_back(dpr_pkg::CH_START);
        foreach (body[i])
        begin
            stim_q.push_back(body[i]);
            ck = ck + body[i];
        end
        stim_q.push_back(dpr_pkg::CH_END);
        if (flaw == FLAW_SUM)
            ck = ck + 8'($urandom_range(1, 255));
        hi_c = hex_char(ck[7:4]);
        lo_c = hex_char(ck[3:0]);
        if (flaw == FLAW_HI_BAD)
            hi_c = non_hex();
        if (flaw == FLAW_LO_BAD)
            lo_c = non_hex();
        stim_q.push_back(hi_c);
        stim_q.push_back(lo_c);
    endtask

    // Byte source: holds a word until taken, idles at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
            byte_ch.rx_byte <= '0;
        end
        else if (!byte_ch.valid || byte_ch.ready)
        begin
            if (sent < stim_q.size() && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                byte_ch.valid <= 1'b1;
                byte_ch.rx_byte <= stim_q[sent];
                sent <= sent + 1;
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    // Result sink stalls at random
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            stall <= 0;
        else
            stall <= stall + 1;
        if (stall >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] body[$];
        int         len;
        int         roll;
        flaw_t      flaw;

        byte_ch.valid = 1'b0;
        byte_ch.rx_byte = '0;
        result_ch.ready = 1'b0;

        // Directed: noise extremes while hunting
        stim_q.push_back(8'h00);
        stim_q.push_back(8'hFF);
        // empty packet, good checksum
        body.delete();
        add_packet(body, FLAW_NONE);
        // sequence id with payload extremes
        body = '{8'h31, 8'h32, dpr_pkg::CH_COLON, 8'h00, 8'hFF};
        add_packet(body, FLAW_NONE);
        // bad high digit
        body.delete();
        add_packet(body, FLAW_HI_BAD);
        // start inside a packet
        stim_q.push_back(dpr_pkg::CH_START);
        stim_q.push_back(8'h41);
        add_packet(body, FLAW_NONE);

        // Random: mostly well-formed packets, some spoilt, restarted or overlong
        while (stim_q.size() < 370)
        begin
            repeat ($urandom_range(0, 2))
            begin
                roll = $urandom_range(0, 255);
                stim_q.push_back(roll == dpr_pkg::CH_START ? 8'h00 : 8'(roll));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                stim_q.push_back(dpr_pkg::CH_START);
                repeat ($urandom_range(0, 5))
                    stim_q.push_back(body_byte());
            end
            roll = $urandom_range(0, 99);
            if (roll < 65)
                len = $urandom_range(0, 8);
            else if (roll < 88)
                len = $urandom_range(9, BUFFER_BYTES - 1);
            else if (roll < 94)
                len = BUFFER_BYTES;
            else
                len = $urandom_range(BUFFER_BYTES + 1, BUFFER_BYTES + 8);
            body.delete();
            repeat (len)
                body.push_back(body_byte());
            if (len >= 3 && $urandom_range(0, 1))
                body[2] = dpr_pkg::CH_COLON;
            roll = $urandom_range(0, 99);
            if (roll < 76)
                flaw = FLAW_NONE;
            else if (roll < 84)
                flaw = FLAW_SUM;
            else if (roll < 92)
                flaw = FLAW_HI_BAD;
            else
                flaw = FLAW_LO_BAD;
            add_packet(body, flaw);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // drain: every byte taken, every reply word seen
        while (sent < stim_q.size() || byte_ch.valid || words_pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/dpr_pkg.sv
design/dpr_rx_if.sv
design/dpr_res_if.sv
design/dpr_datapath.sv
design/dpr_ctrl.sv
design/debug_packet_receiver_unit.sv
tb/sv/dpr_reply_checker.sv
tb/sv/testbench.sv
